// ===== hdl/gic_pkg.sv =====
// ----------------------------------------------------------------------------
// gic_pkg: shared types and constants of the gamepad input conditioner
// Command, error, motor and register codes, field widths and reset values.
// ----------------------------------------------------------------------------
package gic_pkg;

  // Field widths of the channels.
  localparam int CMD_W      = 2;
  localparam int PAD_W      = 2;
  localparam int ERR_W      = 2;
  localparam int BTN_W      = 16;
  localparam int STICK_W    = 8;
  localparam int TRIG_W     = 8;
  localparam int RUMBLE_W   = 15;
  localparam int DIR_W      = 4;
  localparam int MOTOR_W    = 2;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int ELAPSED_W  = 16;
  localparam int DIV_CNT_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE      = 2'd0,
    CMD_RUMBLE_SET  = 2'd1,
    CMD_RUMBLE_STOP = 2'd2
  } gic_cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_NO_CTRL   = 2'd1,
    ERR_NOT_READY = 2'd2,
    ERR_TRANSFER  = 2'd3
  } gic_err_e;

  typedef enum logic [MOTOR_W-1:0] {
    MOTOR_NONE  = 2'd0,
    MOTOR_START = 2'd1,
    MOTOR_STOP  = 2'd2
  } gic_motor_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BUTTON_DELAY    = 3'd0,
    REG_DIR_FIRST_DELAY = 3'd1,
    REG_DIR_INTERVAL    = 3'd2,
    REG_Y_THRESHOLD     = 3'd3,
    REG_X_THRESHOLD     = 3'd4,
    REG_DEAD_ZONE       = 3'd5,
    REG_TRIGGER_MASK    = 3'd6
  } gic_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_FINISH
  } gic_state_e;

  // Digital trigger bits folded in from the analog levels.
  localparam logic [BTN_W-1:0] TRIG_L_BIT = 16'h0040;
  localparam logic [BTN_W-1:0] TRIG_R_BIT = 16'h0020;

  // Register reset values.
  localparam logic [7:0] RST_BUTTON_DELAY    = 8'd20;
  localparam logic [7:0] RST_DIR_FIRST_DELAY = 8'd20;
  localparam logic [7:0] RST_DIR_INTERVAL    = 8'd2;
  localparam logic [7:0] RST_Y_THRESHOLD     = 8'd20;
  localparam logic [7:0] RST_X_THRESHOLD     = 8'd30;
  localparam logic [8:0] RST_DEAD_ZONE       = 9'd20;
  localparam logic [7:0] RST_TRIGGER_MASK    = 8'hC0;

  // The remainder unit retires one dividend bit per cycle.
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ELAPSED_W - 1);

endpackage

// ===== hdl/gic_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gic_cfg_if: register write channel
// Carries a register index and write data under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gic_cfg_if import gic_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/gic_in_if.sv =====
// ----------------------------------------------------------------------------
// gic_in_if: input word channel
// One controller sample or rumble command per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gic_in_if import gic_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [PAD_W-1:0]           pad;
  logic [ERR_W-1:0]           error;
  logic [BTN_W-1:0]           buttons;
  logic signed [STICK_W-1:0]  stick_x;
  logic signed [STICK_W-1:0]  stick_y;
  logic [TRIG_W-1:0]          trigger_left;
  logic [TRIG_W-1:0]          trigger_right;
  logic [RUMBLE_W-1:0]        rumble_duration;
  logic [RUMBLE_W-1:0]        rumble_off_time;
  logic [RUMBLE_W-1:0]        rumble_on_time;

  modport source (
    output valid, output cmd, output pad, output error, output buttons,
    output stick_x, output stick_y, output trigger_left, output trigger_right,
    output rumble_duration, output rumble_off_time, output rumble_on_time,
    input ready
  );
  modport sink (
    input valid, input cmd, input pad, input error, input buttons,
    input stick_x, input stick_y, input trigger_left, input trigger_right,
    input rumble_duration, input rumble_off_time, input rumble_on_time,
    output ready
  );
endinterface

// ===== hdl/gic_out_if.sv =====
// ----------------------------------------------------------------------------
// gic_out_if: result word channel
// Qualified buttons, direction and motor commands for one pad per word.
// ----------------------------------------------------------------------------
interface gic_out_if import gic_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PAD_W-1:0]   pad_out;
  logic [ERR_W-1:0]   error_out;
  logic [BTN_W-1:0]   held_buttons;
  logic [BTN_W-1:0]   pressed_buttons;
  logic [BTN_W-1:0]   repeat_buttons;
  logic [DIR_W-1:0]   direction;
  logic [DIR_W-1:0]   direction_repeat;
  logic [MOTOR_W-1:0] motor_cmd;
  logic               motor_hard_stop;
  logic               reset_request;

  modport source (
    output valid, output pad_out, output error_out, output held_buttons,
    output pressed_buttons, output repeat_buttons, output direction,
    output direction_repeat, output motor_cmd, output motor_hard_stop,
    output reset_request, input ready
  );
  modport sink (
    input valid, input pad_out, input error_out, input held_buttons,
    input pressed_buttons, input repeat_buttons, input direction,
    input direction_repeat, input motor_cmd, input motor_hard_stop,
    input reset_request, output ready
  );
endinterface

// ===== hdl/gamepad_input_conditioner_core.sv =====
// A result word passes CALC and FINISH after its input word is accepted, and DIV
// between them for a good sample of an error-free pad whose rumble pattern runs
// with a nonzero period; no new word is taken before it leaves FINISH. The phase
// comes from a restoring remainder unit that retires one dividend bit per cycle.
// Reset: registers return to their defaults and all pad state clears at once
// (stored error "not ready"); there is no clearing pass.
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_core: per-pad controller qualifier
// Button auto-repeat, stick direction qualification and rumble pattern timing
// for up to PAD_COUNT pads, one word at a time under a small sequencer.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_core import gic_pkg::*; #(
  parameter int PAD_COUNT = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gic_cfg_if.sink   cfg_i,
  gic_in_if.sink    in_i,
  gic_out_if.source res_o
);

  // Pad state is indexed with just the bits the pad count needs.
  localparam int IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int EXT_W = (IDX_W > PAD_W) ? IDX_W : PAD_W;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are taken in any cycle; the user only
  // writes while the block is idle.
  // --------------------------------------------------------------------------
  logic [7:0] btn_delay_q;
  logic [7:0] dir_first_q;
  logic [7:0] dir_interval_q;
  logic [7:0] y_thr_q;
  logic [7:0] x_thr_q;
  logic [8:0] dead_zone_q;
  logic [7:0] trig_mask_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_delay_q    <= RST_BUTTON_DELAY;
      dir_first_q    <= RST_DIR_FIRST_DELAY;
      dir_interval_q <= RST_DIR_INTERVAL;
      y_thr_q        <= RST_Y_THRESHOLD;
      x_thr_q        <= RST_X_THRESHOLD;
      dead_zone_q    <= RST_DEAD_ZONE;
      trig_mask_q    <= RST_TRIGGER_MASK;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BUTTON_DELAY:    btn_delay_q    <= cfg_i.data[7:0];
        REG_DIR_FIRST_DELAY: dir_first_q    <= cfg_i.data[7:0];
        REG_DIR_INTERVAL:    dir_interval_q <= cfg_i.data[7:0];
        REG_Y_THRESHOLD:     y_thr_q        <= cfg_i.data[7:0];
        REG_X_THRESHOLD:     x_thr_q        <= cfg_i.data[7:0];
        REG_DEAD_ZONE:       dead_zone_q    <= cfg_i.data;
        REG_TRIGGER_MASK:    trig_mask_q    <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer. IDLE takes a word, CALC reads the pad state and primes the
  // remainder unit, DIV runs it, FINISH commits state and loads the result
  // register once that register is free.
  // --------------------------------------------------------------------------
  gic_state_e state_q, state_d;
  logic       in_fire;
  logic       div_step;
  logic       finish;
  logic       need_div;
  logic       res_valid_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    div_step = 1'b0;
    finish   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = need_div ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        div_step = 1'b1;
        if (div_cnt_q == DIV_LAST) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!res_valid_q || res_o.ready) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Captured input word.
  // --------------------------------------------------------------------------
  logic [CMD_W-1:0]          cmd_q;
  logic [PAD_W-1:0]          pad_q;
  logic [ERR_W-1:0]          err_q;
  logic [BTN_W-1:0]          btn_q;
  logic signed [STICK_W-1:0] sx_q;
  logic signed [STICK_W-1:0] sy_q;
  logic [TRIG_W-1:0]         tl_q;
  logic [TRIG_W-1:0]         tr_q;
  logic [RUMBLE_W-1:0]       dur_q;
  logic [RUMBLE_W-1:0]       off_q;
  logic [RUMBLE_W-1:0]       on_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= in_i.cmd;
      pad_q <= in_i.pad;
      err_q <= in_i.error;
      btn_q <= in_i.buttons;
      sx_q  <= in_i.stick_x;
      sy_q  <= in_i.stick_y;
      tl_q  <= in_i.trigger_left;
      tr_q  <= in_i.trigger_right;
      dur_q <= in_i.rumble_duration;
      off_q <= in_i.rumble_off_time;
      on_q  <= in_i.rumble_on_time;
    end
  end

  // Words for a pad beyond the pad count touch no state.
  logic             pad_ok;
  logic [EXT_W-1:0] pad_ext;
  logic [IDX_W-1:0] idx;

  assign pad_ok  = ({30'd0, pad_q} < 32'(PAD_COUNT));
  assign pad_ext = EXT_W'(pad_q);
  assign idx     = pad_ext[IDX_W-1:0];

  // --------------------------------------------------------------------------
  // Per-pad state. Each field is read at the current pad only, and all of
  // them are rewritten together when a word finishes.
  // --------------------------------------------------------------------------
  logic [BTN_W-1:0]     prev_q  [PAD_COUNT];
  logic [7:0]           cnt_q   [PAD_COUNT];
  logic [7:0]           cd_q    [PAD_COUNT];
  logic [DIR_W-1:0]     lrd_q   [PAD_COUNT];
  logic [ERR_W-1:0]     le_q    [PAD_COUNT];
  logic [RUMBLE_W-1:0]  len_q   [PAD_COUNT];
  logic [RUMBLE_W-1:0]  stop_q  [PAD_COUNT];
  logic [RUMBLE_W-1:0]  run_q   [PAD_COUNT];
  logic [ELAPSED_W-1:0] el_q    [PAD_COUNT];

  logic [BTN_W-1:0]     cur_prev, prev_d;
  logic [7:0]           cur_cnt, cnt_d;
  logic [7:0]           cur_cd, cd_d;
  logic [DIR_W-1:0]     cur_lrd, lrd_d;
  logic [ERR_W-1:0]     cur_le, le_d;
  logic [RUMBLE_W-1:0]  cur_len, len_d;
  logic [RUMBLE_W-1:0]  cur_stop, stop_d;
  logic [RUMBLE_W-1:0]  cur_run, run_d;
  logic [ELAPSED_W-1:0] cur_el, el_d;

  assign cur_prev = prev_q[idx];
  assign cur_cnt  = cnt_q[idx];
  assign cur_cd   = cd_q[idx];
  assign cur_lrd  = lrd_q[idx];
  assign cur_le   = le_q[idx];
  assign cur_len  = len_q[idx];
  assign cur_stop = stop_q[idx];
  assign cur_run  = run_q[idx];
  assign cur_el   = el_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
        prev_q[i] <= '0;
        cnt_q[i]  <= '0;
        cd_q[i]   <= '0;
        lrd_q[i]  <= '0;
        le_q[i]   <= ERR_NOT_READY;
        len_q[i]  <= '0;
        stop_q[i] <= '0;
        run_q[i]  <= '0;
        el_q[i]   <= '0;
      end
    end else if (finish && pad_ok) begin
      prev_q[idx] <= prev_d;
      cnt_q[idx]  <= cnt_d;
      cd_q[idx]   <= cd_d;
      lrd_q[idx]  <= lrd_d;
      le_q[idx]   <= le_d;
      len_q[idx]  <= len_d;
      stop_q[idx] <= stop_d;
      run_q[idx]  <= run_d;
      el_q[idx]   <= el_d;
    end
  end

  // --------------------------------------------------------------------------
  // Remainder unit: phase = elapsed mod (off time + on time), restoring form,
  // one dividend bit per cycle. A zero period leaves the remainder at zero.
  // --------------------------------------------------------------------------
  logic [ELAPSED_W-1:0] period;
  logic [ELAPSED_W-1:0] rem_q;
  logic [ELAPSED_W-1:0] dvd_q;
  logic [ELAPSED_W-1:0] div_q;
  logic [ELAPSED_W:0]   rem_sh;

  assign period = {1'b0, cur_stop} + {1'b0, cur_run};
  assign rem_sh = {rem_q, dvd_q[ELAPSED_W-1]};

  // The phase matters only for a good sample of a pad with a live pattern
  // that is not being recovered from an error.
  assign need_div = (cmd_q == CMD_SAMPLE) && (err_q == ERR_NONE) && pad_ok &&
                    (cur_le == ERR_NONE) && (cur_len != '0) && (period != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (state_q == ST_CALC) begin
      div_cnt_q <= '0;
    end else if (div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      rem_q <= '0;
      dvd_q <= cur_el;
      div_q <= period;
    end else if (div_step) begin
      dvd_q <= {dvd_q[ELAPSED_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, div_q}) begin
        rem_q <= ELAPSED_W'(rem_sh - {1'b0, div_q});
      end else begin
        rem_q <= rem_sh[ELAPSED_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Qualification logic, evaluated in FINISH from the captured word, the
  // pad state and the phase.
  // --------------------------------------------------------------------------
  logic [BTN_W-1:0]     held_w;
  logic [8:0]           ax, ay, sum_w;
  logic                 dead;
  logic [DIR_W-1:0]     dir_w;
  logic [ELAPSED_W-1:0] el_inc;

  logic [BTN_W-1:0]     o_held, o_pressed, o_rep;
  logic [DIR_W-1:0]     o_dir, o_drep;
  logic [MOTOR_W-1:0]   o_mcmd;
  logic                 o_hard, o_rreq;
  logic [RUMBLE_W-1:0]  len_w;
  logic [DIR_W-1:0]     lrd_w;

  assign held_w = btn_q |
                  ((|(tl_q & trig_mask_q)) ? TRIG_L_BIT : '0) |
                  ((|(tr_q & trig_mask_q)) ? TRIG_R_BIT : '0);

  // Magnitudes run to 128 for the most negative deflection.
  assign ax    = sx_q[7] ? 9'(9'd256 - {1'b0, sx_q}) : {1'b0, sx_q};
  assign ay    = sy_q[7] ? 9'(9'd256 - {1'b0, sy_q}) : {1'b0, sy_q};
  assign sum_w = 9'(ax + ay);
  assign dead  = (sum_w < dead_zone_q);

  // Up/down from the vertical axis (positive is up), left/right from the
  // horizontal axis.
  assign dir_w = {(ay > {1'b0, y_thr_q}) && !sy_q[7],
                  (ay > {1'b0, y_thr_q}) &&  sy_q[7],
                  (ax > {1'b0, x_thr_q}) && !sx_q[7],
                  (ax > {1'b0, x_thr_q}) &&  sx_q[7]};

  assign el_inc = cur_el + 1'b1;

  always_comb begin
    prev_d    = cur_prev;
    cnt_d     = cur_cnt;
    cd_d      = cur_cd;
    lrd_d     = cur_lrd;
    le_d      = cur_le;
    len_d     = cur_len;
    stop_d    = cur_stop;
    run_d     = cur_run;
    el_d      = cur_el;
    o_held    = '0;
    o_pressed = '0;
    o_rep     = '0;
    o_dir     = '0;
    o_drep    = '0;
    o_mcmd    = MOTOR_NONE;
    o_hard    = 1'b0;
    o_rreq    = 1'b0;
    len_w     = cur_len;
    lrd_w     = cur_lrd;
    case (cmd_q)
      CMD_SAMPLE: begin
        if (err_q != ERR_NONE) begin
          // A failed sample drops the held buttons; counters and the
          // pattern survive until the pad recovers.
          le_d   = err_q;
          prev_d = '0;
          o_rreq = (err_q == ERR_NO_CTRL);
        end else begin
          // Recovery from a stored error stops the motor and ends the pattern.
          if (cur_le != ERR_NONE) begin
            o_hard = 1'b1;
            len_w  = '0;
          end

          // Button auto-repeat: a press reports at once, a held set repeats
          // after the delay; the hold counter saturates.
          o_held = held_w;
          if ((held_w != '0) && (cur_prev == held_w)) begin
            if (cur_cnt > btn_delay_q) begin
              o_rep = held_w;
            end else if (cur_cnt != 8'hFF) begin
              cnt_d = cur_cnt + 1'b1;
            end
          end else begin
            cnt_d = '0;
            o_rep = held_w;
          end

          // Stick direction repeat with the dead zone clearing the memory.
          o_dir = dir_w;
          if (dead) lrd_w = '0;
          if (cur_cd != '0) begin
            cd_d = dead ? 8'd0 : 8'(cur_cd - 8'd1);
          end else begin
            o_drep = dir_w;
            if (dir_w != '0) begin
              cd_d  = (lrd_w == dir_w) ? dir_interval_q : dir_first_q;
              lrd_w = dir_w;
            end
          end
          lrd_d = lrd_w;

          o_pressed = held_w & ~cur_prev;
          prev_d    = held_w;
          le_d      = ERR_NONE;

          // Rumble pattern: start at phase zero, stop at the off phase, and
          // a hard stop once the elapsed count runs past the length.
          if (len_w != '0) begin
            if (rem_q == '0) begin
              o_mcmd = MOTOR_START;
            end else if (rem_q == {1'b0, cur_stop}) begin
              o_mcmd = MOTOR_STOP;
            end
            el_d = el_inc;
            if (el_inc > {1'b0, len_w}) begin
              o_hard = 1'b1;
              len_w  = '0;
            end
          end
          len_d = len_w;
        end
      end
      CMD_RUMBLE_SET: begin
        if (cur_le == ERR_NONE) begin
          len_d  = dur_q;
          stop_d = off_q;
          run_d  = on_q;
          el_d   = '0;
        end
      end
      CMD_RUMBLE_STOP: begin
        if (cur_le == ERR_NONE) begin
          len_d  = '0;
          o_hard = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register. It holds a finished word until taken, while the input
  // side already takes the next word.
  // --------------------------------------------------------------------------
  logic [PAD_W-1:0]   res_pad_q;
  logic [ERR_W-1:0]   res_err_q;
  logic [BTN_W-1:0]   res_held_q, res_pressed_q, res_rep_q;
  logic [DIR_W-1:0]   res_dir_q, res_drep_q;
  logic [MOTOR_W-1:0] res_mcmd_q;
  logic               res_hard_q, res_rreq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (finish) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_pad_q     <= pad_q;
      res_err_q     <= pad_ok ? le_d : '0;
      res_held_q    <= pad_ok ? o_held : '0;
      res_pressed_q <= pad_ok ? o_pressed : '0;
      res_rep_q     <= pad_ok ? o_rep : '0;
      res_dir_q     <= pad_ok ? o_dir : '0;
      res_drep_q    <= pad_ok ? o_drep : '0;
      res_mcmd_q    <= pad_ok ? o_mcmd : MOTOR_NONE;
      res_hard_q    <= pad_ok && o_hard;
      res_rreq_q    <= pad_ok && o_rreq;
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.pad_out          = res_pad_q;
  assign res_o.error_out        = res_err_q;
  assign res_o.held_buttons     = res_held_q;
  assign res_o.pressed_buttons  = res_pressed_q;
  assign res_o.repeat_buttons   = res_rep_q;
  assign res_o.direction        = res_dir_q;
  assign res_o.direction_repeat = res_drep_q;
  assign res_o.motor_cmd        = res_mcmd_q;
  assign res_o.motor_hard_stop  = res_hard_q;
  assign res_o.reset_request    = res_rreq_q;

`ifndef SYNTHESIS
  // Only one word is in work at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input accepted while a word is still in work");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && res_valid_q && !res_o.ready) |=> state_q == ST_FINISH)
    else $error("result register overwritten before it was taken");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < div_q)
    else $error("remainder unit out of range");

  // The division runs exactly one step per dividend bit.
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_cnt_q == DIV_LAST) |=> state_q == ST_FINISH)
    else $error("remainder unit did not finish on its last step");
`endif

endmodule

// ===== tb/gamepad_input_conditioner_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_core_test: self-checking bench of the conditioner
// Drives sample and rumble words with random idling on both channels.
// Register settings change between phases. Each result word is checked field
// by field against a cycle-free behavioral model of the pad state.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_core_test import gic_pkg::*; ();

  localparam int NUM_PADS = 4;

  // The command field has one code the package leaves unnamed; it must be inert.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  // Register index beyond the defined ones; a write to it must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Direction bits of the result word.
  localparam logic [DIR_W-1:0] DIR_LEFT  = 4'b0001;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 4'b0010;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 4'b0100;
  localparam logic [DIR_W-1:0] DIR_UP    = 4'b1000;

  // One input word as the bench builds it. Stick values are kept as raw bits.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [PAD_W-1:0]    pad;
    logic [ERR_W-1:0]    error;
    logic [BTN_W-1:0]    buttons;
    logic [STICK_W-1:0]  stick_x;
    logic [STICK_W-1:0]  stick_y;
    logic [TRIG_W-1:0]   trigger_left;
    logic [TRIG_W-1:0]   trigger_right;
    logic [RUMBLE_W-1:0] rumble_duration;
    logic [RUMBLE_W-1:0] rumble_off_time;
    logic [RUMBLE_W-1:0] rumble_on_time;
  } pad_word_t;

  // One result word as the block should produce it.
  typedef struct packed {
    logic [PAD_W-1:0]   pad;
    logic [ERR_W-1:0]   error;
    logic [BTN_W-1:0]   held;
    logic [BTN_W-1:0]   pressed;
    logic [BTN_W-1:0]   repeated;
    logic [DIR_W-1:0]   dir;
    logic [DIR_W-1:0]   dir_repeat;
    logic [MOTOR_W-1:0] motor;
    logic               hard_stop;
    logic               reset_req;
  } pad_report_t;

  logic clk = 1'b0;
  logic rst_n;

  gic_cfg_if cfg_ch ();
  gic_in_if  in_ch ();
  gic_out_if res_ch ();

  gamepad_input_conditioner_core #(
    .PAD_COUNT(NUM_PADS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .res_o (res_ch)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies that the model works from. They follow every accepted
  // register write, so they always match what the block holds.
  logic [7:0] btn_delay;
  logic [7:0] dir_first;
  logic [7:0] dir_interval;
  logic [7:0] y_thresh;
  logic [7:0] x_thresh;
  logic [8:0] dead_zone_lim;
  logic [7:0] trig_mask;

  // Pad state of the model, one entry per pad.
  logic [BTN_W-1:0]     held_prev     [NUM_PADS];
  logic [7:0]           btn_hold_cnt  [NUM_PADS];
  logic [7:0]           dir_countdown [NUM_PADS];
  logic [DIR_W-1:0]     dir_last      [NUM_PADS];
  logic [ERR_W-1:0]     pad_err       [NUM_PADS];
  logic [RUMBLE_W-1:0]  rumble_len    [NUM_PADS];
  logic [RUMBLE_W-1:0]  rumble_off    [NUM_PADS];
  logic [RUMBLE_W-1:0]  rumble_on     [NUM_PADS];
  logic [ELAPSED_W-1:0] rumble_count  [NUM_PADS];

  // Last sample content sent to each pad, so that the random traffic can hold
  // buttons and stick steady long enough for the repeat logic to fire.
  logic [BTN_W-1:0]   stim_buttons [NUM_PADS];
  logic [STICK_W-1:0] stim_x       [NUM_PADS];
  logic [STICK_W-1:0] stim_y       [NUM_PADS];
  logic [TRIG_W-1:0]  stim_tl      [NUM_PADS];
  logic [TRIG_W-1:0]  stim_tr      [NUM_PADS];

  pad_report_t pending_reports[$];
  int          mismatches = 0;
  // When set, neither side inserts idle cycles.
  bit          quiet = 1'b0;

  function automatic int idle_cycles();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  // Applies one accepted word to the pad state and returns the result word
  // that the block has to produce for it.
  function automatic pad_report_t condition_word(input pad_word_t w);
    pad_report_t r;
    int          p;
    logic [8:0]  mag_x;
    logic [8:0]  mag_y;
    logic [8:0]  dev_sum;
    logic [BTN_W-1:0] prev;
    logic [16:0] period;
    logic [16:0] phase;
    r = '0;
    p = int'(w.pad);
    r.pad = w.pad;
    if (w.cmd == CMD_SAMPLE) begin
      if (w.error != ERR_NONE) begin
        // A failed read records the code, forgets the held buttons and may request a reset.
        pad_err[p]   = w.error;
        held_prev[p] = '0;
        r.reset_req  = (w.error == ERR_NO_CTRL);
      end else begin
        mag_x = w.stick_x[7] ? 9'd256 - {1'b0, w.stick_x} : {1'b0, w.stick_x};
        mag_y = w.stick_y[7] ? 9'd256 - {1'b0, w.stick_y} : {1'b0, w.stick_y};
        prev  = held_prev[p];

        // Coming back from an error always kills the motor and the pattern.
        if (pad_err[p] != ERR_NONE) begin
          r.hard_stop   = 1'b1;
          rumble_len[p] = '0;
        end

        r.held = w.buttons;
        if ((w.trigger_left & trig_mask) != '0) r.held = r.held | TRIG_L_BIT;
        if ((w.trigger_right & trig_mask) != '0) r.held = r.held | TRIG_R_BIT;

        if (r.held != '0 && prev == r.held) begin
          if (btn_hold_cnt[p] > btn_delay) begin
            r.repeated = r.held;
          end else if (btn_hold_cnt[p] != 8'hFF) begin
            btn_hold_cnt[p] = btn_hold_cnt[p] + 8'd1;
          end
        end else begin
          btn_hold_cnt[p] = '0;
          r.repeated      = r.held;
        end

        if (mag_y > {1'b0, y_thresh}) r.dir = r.dir | (w.stick_y[7] ? DIR_DOWN : DIR_UP);
        if (mag_x > {1'b0, x_thresh}) r.dir = r.dir | (w.stick_x[7] ? DIR_LEFT : DIR_RIGHT);

        // Near the center the remembered direction and the countdown reset.
        dev_sum = mag_x + mag_y;
        if (dev_sum < dead_zone_lim) dir_last[p] = '0;
        if (dir_countdown[p] != '0) begin
          dir_countdown[p] = dir_countdown[p] - 8'd1;
          if (dev_sum < dead_zone_lim) dir_countdown[p] = '0;
        end else begin
          r.dir_repeat = r.dir;
          if (r.dir != '0) begin
            dir_countdown[p] = (dir_last[p] == r.dir) ? dir_interval : dir_first;
            dir_last[p]      = r.dir;
          end
        end

        r.pressed    = r.held & ~prev;
        held_prev[p] = r.held;
        pad_err[p]   = ERR_NONE;

        // The pattern runs on the sample count; a zero period stays at phase 0.
        if (rumble_len[p] != '0) begin
          period = {2'b0, rumble_off[p]} + {2'b0, rumble_on[p]};
          phase  = (period == '0) ? '0 : {1'b0, rumble_count[p]} % period;
          if (phase == '0) r.motor = MOTOR_START;
          else if (phase == {2'b0, rumble_off[p]}) r.motor = MOTOR_STOP;
          rumble_count[p] = rumble_count[p] + 16'd1;
          if (rumble_count[p] > {1'b0, rumble_len[p]}) begin
            r.hard_stop   = 1'b1;
            rumble_len[p] = '0;
          end
        end
      end
    end else if (w.cmd == CMD_RUMBLE_SET) begin
      if (pad_err[p] == ERR_NONE) begin
        rumble_len[p]   = w.rumble_duration;
        rumble_off[p]   = w.rumble_off_time;
        rumble_on[p]    = w.rumble_on_time;
        rumble_count[p] = '0;
      end
    end else if (w.cmd == CMD_RUMBLE_STOP) begin
      if (pad_err[p] == ERR_NONE) begin
        rumble_len[p] = '0;
        r.hard_stop   = 1'b1;
      end
    end
    r.error = pad_err[p];
    return r;
  endfunction

  // Sends one word after a random gap; the expected result is queued at the
  // edge that accepts the word, so model and block see the same order.
  task automatic send_word(input pad_word_t w);
    int gap;
    gap = idle_cycles();
    repeat (gap) @(negedge clk);
    in_ch.cmd             = w.cmd;
    in_ch.pad             = w.pad;
    in_ch.error           = w.error;
    in_ch.buttons         = w.buttons;
    in_ch.stick_x         = w.stick_x;
    in_ch.stick_y         = w.stick_y;
    in_ch.trigger_left    = w.trigger_left;
    in_ch.trigger_right   = w.trigger_right;
    in_ch.rumble_duration = w.rumble_duration;
    in_ch.rumble_off_time = w.rumble_off_time;
    in_ch.rumble_on_time  = w.rumble_on_time;
    in_ch.valid           = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_reports.push_back(condition_word(w));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Register writes wait until every result is back, so the block is idle.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    while (pending_reports.size() != 0) @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_BUTTON_DELAY:    btn_delay     = value[7:0];
      REG_DIR_FIRST_DELAY: dir_first     = value[7:0];
      REG_DIR_INTERVAL:    dir_interval  = value[7:0];
      REG_Y_THRESHOLD:     y_thresh      = value[7:0];
      REG_X_THRESHOLD:     x_thresh      = value[7:0];
      REG_DEAD_ZONE:       dead_zone_lim = value;
      REG_TRIGGER_MASK:    trig_mask     = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic write_all_registers(input int bd, input int fd, input int ri, input int yt,
                                     input int xt, input int dz, input int tm);
    write_register(REG_BUTTON_DELAY, CFG_DATA_W'(bd));
    write_register(REG_DIR_FIRST_DELAY, CFG_DATA_W'(fd));
    write_register(REG_DIR_INTERVAL, CFG_DATA_W'(ri));
    write_register(REG_Y_THRESHOLD, CFG_DATA_W'(yt));
    write_register(REG_X_THRESHOLD, CFG_DATA_W'(xt));
    write_register(REG_DEAD_ZONE, CFG_DATA_W'(dz));
    write_register(REG_TRIGGER_MASK, CFG_DATA_W'(tm));
  endtask

  function automatic pad_word_t make_sample(input int pad, input logic [ERR_W-1:0] err,
                                            input logic [BTN_W-1:0] btn,
                                            input logic [STICK_W-1:0] x,
                                            input logic [STICK_W-1:0] y,
                                            input logic [TRIG_W-1:0] tl,
                                            input logic [TRIG_W-1:0] tr);
    pad_word_t w;
    w.cmd             = CMD_SAMPLE;
    w.pad             = PAD_W'(pad);
    w.error           = err;
    w.buttons         = btn;
    w.stick_x         = x;
    w.stick_y         = y;
    w.trigger_left    = tl;
    w.trigger_right   = tr;
    w.rumble_duration = RUMBLE_W'($urandom);
    w.rumble_off_time = RUMBLE_W'($urandom);
    w.rumble_on_time  = RUMBLE_W'($urandom);
    return w;
  endfunction

  // Rumble and unknown commands; the sample fields carry noise only.
  function automatic pad_word_t make_command(input logic [CMD_W-1:0] cmd, input int pad,
                                             input int dur, input int off, input int on);
    pad_word_t w;
    w = make_sample(pad, ERR_W'($urandom), BTN_W'($urandom), STICK_W'($urandom),
                    STICK_W'($urandom), TRIG_W'($urandom), TRIG_W'($urandom));
    w.cmd             = cmd;
    w.rumble_duration = RUMBLE_W'(dur);
    w.rumble_off_time = RUMBLE_W'(off);
    w.rumble_on_time  = RUMBLE_W'(on);
    return w;
  endfunction

  // Random traffic: mostly good samples that often repeat the previous content
  // of the pad, with some errors, short rumble patterns, stops and noise.
  function automatic pad_word_t random_word();
    pad_word_t w;
    int        p;
    int        roll;
    int        dur;
    int        off;
    int        on;
    p    = $urandom_range(0, NUM_PADS - 1);
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      if ($urandom_range(0, 99) >= 65) begin
        case ($urandom_range(0, 2))
          0:       stim_buttons[p] = BTN_W'($urandom);
          1:       stim_buttons[p] = BTN_W'(1) << $urandom_range(0, BTN_W - 1);
          default: stim_buttons[p] = '0;
        endcase
        stim_tl[p] = TRIG_W'($urandom);
        stim_tr[p] = TRIG_W'($urandom);
      end
      if ($urandom_range(0, 99) >= 65) begin
        if ($urandom_range(0, 2) == 0) begin
          stim_x[p] = STICK_W'($urandom_range(0, 12)) - STICK_W'(6);
          stim_y[p] = STICK_W'($urandom_range(0, 12)) - STICK_W'(6);
        end else begin
          stim_x[p] = STICK_W'($urandom);
          stim_y[p] = STICK_W'($urandom);
        end
      end
      w = make_sample(p, ERR_NONE, stim_buttons[p], stim_x[p], stim_y[p],
                      stim_tl[p], stim_tr[p]);
      if ($urandom_range(0, 99) < 8) w.error = ERR_W'($urandom_range(1, 3));
    end else if (roll < 90) begin
      if ($urandom_range(0, 9) == 0) begin
        dur = $urandom_range(0, 32767);
        off = $urandom_range(0, 32767);
        on  = $urandom_range(0, 32767);
      end else begin
        dur = $urandom_range(0, 40);
        off = $urandom_range(0, 8);
        on  = $urandom_range(0, 8);
      end
      w = make_command(CMD_RUMBLE_SET, p, dur, off, on);
    end else if (roll < 96) begin
      w = make_command(CMD_RUMBLE_STOP, p, $urandom, $urandom, $urandom);
    end else begin
      w = make_command(CMD_UNKNOWN, p, $urandom, $urandom, $urandom);
    end
    return w;
  endfunction

  // Runs random traffic; every forty words the idling is switched off or on so
  // that some stretches run back to back on both channels.
  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_word(random_word());
    end
    quiet = 1'b0;
  endtask

  // Special cases at the reset settings: recovery from the reset error, stick
  // and button extremes, every error code, rumble commands refused while a pad
  // is in error, a short pattern to its end, a zero period, a stop and the
  // unknown command.
  task automatic test_special_cases();
    send_word(make_sample(0, ERR_NONE, 16'hFFFF, 8'h80, 8'h80, 8'hFF, 8'hFF));
    send_word(make_sample(0, ERR_NONE, 16'hFFFF, 8'h80, 8'h80, 8'hFF, 8'hFF));
    send_word(make_sample(1, ERR_NONE, 16'h0000, 8'h7F, 8'h7F, 8'h3F, 8'h3F));
    send_word(make_sample(1, ERR_NO_CTRL, 16'hA5A5, 8'h7F, 8'h80, 8'hC0, 8'h40));
    send_word(make_sample(2, ERR_TRANSFER, 16'h5A5A, 8'h80, 8'h7F, 8'h80, 8'h80));
    send_word(make_sample(3, ERR_NOT_READY, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(make_command(CMD_RUMBLE_SET, 1, 5, 1, 1));
    send_word(make_command(CMD_RUMBLE_STOP, 1, 0, 0, 0));
    send_word(make_sample(1, ERR_NONE, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(make_command(CMD_RUMBLE_SET, 1, 4, 1, 2));
    repeat (5) send_word(make_sample(1, ERR_NONE, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(make_command(CMD_RUMBLE_SET, 0, 2, 0, 0));
    repeat (3) send_word(make_sample(0, ERR_NONE, 16'h8000, 8'h00, 8'h7F, 8'h00, 8'h00));
    send_word(make_command(CMD_RUMBLE_SET, 0, 32767, 32767, 32767));
    send_word(make_sample(0, ERR_NONE, 16'h8000, 8'h80, 8'h00, 8'h00, 8'h00));
    send_word(make_command(CMD_RUMBLE_STOP, 0, 0, 0, 0));
    send_word(make_command(CMD_UNKNOWN, 0, 32767, 0, 32767));
  endtask

  // Every register at its lowest value, plus a write to an unused index that
  // must leave all settings alone.
  task automatic test_low_settings();
    write_all_registers(0, 0, 0, 0, 0, 0, 0);
    write_register(REG_UNUSED, 9'h1FF);
    run_random(200);
  endtask

  task automatic test_high_settings();
    write_all_registers(255, 255, 255, 128, 128, 256, 255);
    run_random(200);
  endtask

  task automatic test_reset_settings();
    write_all_registers(int'(RST_BUTTON_DELAY), int'(RST_DIR_FIRST_DELAY),
                        int'(RST_DIR_INTERVAL), int'(RST_Y_THRESHOLD),
                        int'(RST_X_THRESHOLD), int'(RST_DEAD_ZONE),
                        int'(RST_TRIGGER_MASK));
    run_random(200);
  endtask

  // Random settings; short delays are favored so that repeats happen often.
  task automatic test_random_settings();
    repeat (3) begin
      write_all_registers($urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 255),
                          $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 255),
                          $urandom_range(0, 4),
                          $urandom_range(0, 128), $urandom_range(0, 128),
                          $urandom_range(0, 256), $urandom_range(0, 255));
      run_random(200);
    end
  endtask

  task automatic compare_field(input string field, input logic [BTN_W-1:0] want,
                               input logic [BTN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Result checker: each accepted result word is matched against the oldest
  // expectation.
  always @(posedge clk) begin : report_check
    pad_report_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result word with no expectation, expected none, got pad %0d",
                 $time, res_ch.pad_out);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("pad_out", BTN_W'(want.pad), BTN_W'(res_ch.pad_out));
        compare_field("error_out", BTN_W'(want.error), BTN_W'(res_ch.error_out));
        compare_field("held_buttons", want.held, res_ch.held_buttons);
        compare_field("pressed_buttons", want.pressed, res_ch.pressed_buttons);
        compare_field("repeat_buttons", want.repeated, res_ch.repeat_buttons);
        compare_field("direction", BTN_W'(want.dir), BTN_W'(res_ch.direction));
        compare_field("direction_repeat", BTN_W'(want.dir_repeat),
                      BTN_W'(res_ch.direction_repeat));
        compare_field("motor_cmd", BTN_W'(want.motor), BTN_W'(res_ch.motor_cmd));
        compare_field("motor_hard_stop", BTN_W'(want.hard_stop),
                      BTN_W'(res_ch.motor_hard_stop));
        compare_field("reset_request", BTN_W'(want.reset_req),
                      BTN_W'(res_ch.reset_request));
      end
    end
  end

  // Result side: ready drops for a random number of cycles before each word.
  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = idle_cycles();
      repeat (stall) @(negedge clk);
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
      res_ch.ready = 1'b0;
    end
  end

  // Watchdog; the slowest correct run needs well under a tenth of this.
  initial begin : watchdog
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin : main_sequence
    rst_n        = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = '0;
    in_ch.pad    = '0;
    in_ch.error  = '0;
    in_ch.buttons         = '0;
    in_ch.stick_x         = '0;
    in_ch.stick_y         = '0;
    in_ch.trigger_left    = '0;
    in_ch.trigger_right   = '0;
    in_ch.rumble_duration = '0;
    in_ch.rumble_off_time = '0;
    in_ch.rumble_on_time  = '0;

    // Model state after reset: reset settings, every pad marked not ready.
    btn_delay     = RST_BUTTON_DELAY;
    dir_first     = RST_DIR_FIRST_DELAY;
    dir_interval  = RST_DIR_INTERVAL;
    y_thresh      = RST_Y_THRESHOLD;
    x_thresh      = RST_X_THRESHOLD;
    dead_zone_lim = RST_DEAD_ZONE;
    trig_mask     = RST_TRIGGER_MASK;
    for (int p = 0; p < NUM_PADS; p++) begin
      held_prev[p]     = '0;
      btn_hold_cnt[p]  = '0;
      dir_countdown[p] = '0;
      dir_last[p]      = '0;
      pad_err[p]       = ERR_NOT_READY;
      rumble_len[p]    = '0;
      rumble_off[p]    = '0;
      rumble_on[p]     = '0;
      rumble_count[p]  = '0;
      stim_buttons[p]  = '0;
      stim_x[p]        = '0;
      stim_y[p]        = '0;
      stim_tl[p]       = '0;
      stim_tr[p]       = '0;
    end

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_special_cases();
    test_low_settings();
    test_high_settings();
    test_reset_settings();
    test_random_settings();

    // Drain the results, then give the block its full latency once more so a
    // stray extra word would still be caught.
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
